// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define TSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Types and constants shared by the signed timestamp arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

	localparam int SEC_W = 48;
	localparam int NS_W  = 30;

	// Nanoseconds per second, one bit wider than the field to hold sums.
	localparam logic [NS_W:0]   NS_PER_SEC = 31'd1000000000;
	localparam logic [NS_W-1:0] NS_MAX     = 30'd999999999;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_AVG  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [SEC_W-1:0] sec;
		logic [NS_W-1:0]  ns;
	} mag_t;

	typedef struct packed {
		logic pos;
		mag_t mag;
	} stamp_t;

	// Stage 1: clamped operands.
	typedef struct packed {
		op_t    op;
		stamp_t a;
		stamp_t b;
	} opnd_t;

	// Stage 2: operands ordered by magnitude, result sign settled.
	typedef struct packed {
		op_t  op;
		logic pos;
		logic sub;
		mag_t hi;
		mag_t lo;
	} order_t;

	// Stage 3: raw sums or differences plus the pending carry or borrow.
	typedef struct packed {
		op_t              op;
		logic             pos;
		logic             sub;
		logic             fix;
		logic [NS_W:0]    ns;
		logic [SEC_W-1:0] sec;
	} raw_t;

	// Stage 4: normalized signed sum or difference.
	typedef struct packed {
		op_t  op;
		logic pos;
		mag_t mag;
	} sum_t;

endpackage

`default_nettype wire

// ===== rtl/core/signed_timestamp_add_sub_avg_top.sv =====
// ----------------------------------------------------------------------------
// signed_timestamp_add_sub_avg_top
// Pipelined signed add, unsigned subtract and signed average of timestamps.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_stall is low and returns one result per
// item, in order. The five register stages are clamp, magnitude compare and
// ordering, raw add or subtract, carry or borrow of one second, and then
// the average halving with the output register. Each stage holds its
// item while the one after it is full and stalled, so req_stall rises only
// when all five stages hold items and res_stall is high. Timestamps are sign
// and magnitude with res_positive set meaning non-negative; nanoseconds above
// 999999999 are saturated on entry and seconds wrap at 48 bits. Operation
// code three returns a non-negative zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module signed_timestamp_add_sub_avg_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  operation,
	input  wire logic        a_positive,
	input  wire logic [47:0] a_seconds,
	input  wire logic [29:0] a_nanos,
	input  wire logic        b_positive,
	input  wire logic [47:0] b_seconds,
	input  wire logic [29:0] b_nanos,
	// Result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             res_positive,
	output logic [47:0]      res_seconds,
	output logic [29:0]      res_nanos
);

	tsa_pkg::opnd_t  opnd;
	tsa_pkg::order_t order_s2;
	tsa_pkg::sum_t   sum_s4;
	tsa_pkg::stamp_t res_s5;
	logic            valid_s2;
	logic            valid_s4;
	logic            order_adv;
	logic            addsub_adv;
	logic            halve_adv;

	// Pack the request fields; signs are taken as given, subtract ignores them.
	always_comb begin
		opnd.op        = tsa_pkg::op_t'(operation);
		opnd.a.pos     = a_positive;
		opnd.a.mag.sec = a_seconds;
		opnd.a.mag.ns  = a_nanos;
		opnd.b.pos     = b_positive;
		opnd.b.mag.sec = b_seconds;
		opnd.b.mag.ns  = b_nanos;
	end

	// Stages 1-2: clamp, then order operands by magnitude.
	tsa_order u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (req_valid),
		.opnd     (opnd),
		.adv_in   (addsub_adv),
		.adv_out  (order_adv),
		.valid_s2 (valid_s2),
		.order_s2 (order_s2)
	);

	// Stages 3-4: add or subtract magnitudes, then normalize nanoseconds.
	tsa_addsub u_addsub (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.order_s2 (order_s2),
		.adv_in   (halve_adv),
		.adv_out  (addsub_adv),
		.valid_s4 (valid_s4),
		.sum_s4   (sum_s4)
	);

	// Stage 5: average halving and the output register.
	tsa_halve u_halve (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s4 (valid_s4),
		.sum_s4   (sum_s4),
		.stall    (res_stall),
		.adv_out  (halve_adv),
		.valid_s5 (res_valid),
		.res_s5   (res_s5)
	);

	// Hold the request side only when the first stage cannot advance.
	assign req_stall    = !order_adv;
	assign res_positive = res_s5.pos;
	assign res_seconds  = res_s5.mag.sec;
	assign res_nanos    = res_s5.mag.ns;

	// A stalled request means the pipe is backed up from the result side.
	`TSA_ASSERT_IMP(a_stall_full, req_stall, res_valid && res_stall && valid_s4,
		"request stalled while the pipeline has room")
	// Normalization leaves nanoseconds within one second.
	`TSA_ASSERT_IMP(a_s4_ns_range, valid_s4, sum_s4.mag.ns <= tsa_pkg::NS_MAX,
		"normalized nanoseconds out of range")
	// Results never carry nanoseconds of a full second or more.
	`TSA_ASSERT_IMP(a_res_ns_range, res_valid, res_nanos <= tsa_pkg::NS_MAX,
		"result nanoseconds out of range")
	// An item taken from a full stage 4 lands in the output register.
	`TSA_ASSERT_NXT(a_s5_load, valid_s4 && halve_adv, res_valid,
		"item lost between stage 4 and the output")

endmodule

`default_nettype wire

// ===== rtl/core/tsa_order.sv =====
// ----------------------------------------------------------------------------
// tsa_order
// Stages 1 and 2: clamp nanoseconds, compare magnitudes and order operands.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_order (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	input  wire tsa_pkg::opnd_t opnd,
	input  wire logic           adv_in,
	output logic                adv_out,
	output logic                valid_s2,
	output tsa_pkg::order_t     order_s2
);

	logic            valid_s1;
	tsa_pkg::opnd_t  opnd_s1;
	tsa_pkg::opnd_t  clamp;
	tsa_pkg::order_t order;
	logic            en_s1;
	logic            en_s2;
	logic            sec_eq;
	logic            a_big;

	assign en_s2   = !valid_s2 || adv_in;
	assign en_s1   = !valid_s1 || en_s2;
	assign adv_out = en_s1;

	// Saturate out-of-range nanoseconds.
	always_comb begin
		clamp = opnd;
		if (opnd.a.mag.ns > tsa_pkg::NS_MAX) begin
			clamp.a.mag.ns = tsa_pkg::NS_MAX;
		end
		if (opnd.b.mag.ns > tsa_pkg::NS_MAX) begin
			clamp.b.mag.ns = tsa_pkg::NS_MAX;
		end
	end

	assign sec_eq = (opnd_s1.a.mag.sec == opnd_s1.b.mag.sec);
	assign a_big  = (opnd_s1.a.mag.sec > opnd_s1.b.mag.sec) ||
		(sec_eq && (opnd_s1.a.mag.ns >= opnd_s1.b.mag.ns));

	always_comb begin
		order.op = opnd_s1.op;
		order.hi = a_big ? opnd_s1.a.mag : opnd_s1.b.mag;
		order.lo = a_big ? opnd_s1.b.mag : opnd_s1.a.mag;
		case (opnd_s1.op)
			tsa_pkg::OP_SUB: begin
				order.sub = 1'b1;
				order.pos = a_big;
			end
			default: begin
				order.sub = opnd_s1.a.pos ^ opnd_s1.b.pos;
				order.pos = (order.sub && !a_big) ? opnd_s1.b.pos : opnd_s1.a.pos;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) opnd_s1  <= clamp;
		if (en_s2) order_s2 <= order;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tsa_addsub.sv =====
// ----------------------------------------------------------------------------
// tsa_addsub
// Stages 3 and 4: magnitude add or subtract, then carry or borrow a second.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_addsub (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s2,
	input  wire tsa_pkg::order_t order_s2,
	input  wire logic            adv_in,
	output logic                 adv_out,
	output logic                 valid_s4,
	output tsa_pkg::sum_t        sum_s4
);

	logic                        valid_s3;
	tsa_pkg::raw_t               raw_s3;
	tsa_pkg::raw_t               raw;
	tsa_pkg::sum_t               sum;
	logic                        en_s3;
	logic                        en_s4;
	logic [tsa_pkg::NS_W:0]      ns_sum;
	logic [tsa_pkg::NS_W:0]      ns_dif;
	logic [tsa_pkg::NS_W:0]      ns_fix;

	assign en_s4   = !valid_s4 || adv_in;
	assign en_s3   = !valid_s3 || en_s4;
	assign adv_out = en_s3;

	assign ns_sum = {1'b0, order_s2.hi.ns} + {1'b0, order_s2.lo.ns};
	assign ns_dif = {1'b0, order_s2.hi.ns} - {1'b0, order_s2.lo.ns};

	always_comb begin
		raw.op  = order_s2.op;
		raw.pos = order_s2.pos;
		raw.sub = order_s2.sub;
		if (order_s2.sub) begin
			raw.ns  = ns_dif;
			raw.fix = (order_s2.hi.ns < order_s2.lo.ns);
			raw.sec = order_s2.hi.sec - order_s2.lo.sec;
		end else begin
			raw.ns  = ns_sum;
			raw.fix = (ns_sum > {1'b0, tsa_pkg::NS_MAX});
			raw.sec = order_s2.hi.sec + order_s2.lo.sec;
		end
	end

	// Move one second across the nanosecond boundary where needed.
	always_comb begin
		ns_fix      = raw_s3.ns;
		sum.op      = raw_s3.op;
		sum.pos     = raw_s3.pos;
		sum.mag.sec = raw_s3.sec;
		if (raw_s3.fix) begin
			if (raw_s3.sub) begin
				ns_fix      = raw_s3.ns + tsa_pkg::NS_PER_SEC;
				sum.mag.sec = raw_s3.sec - 48'd1;
			end else begin
				ns_fix      = raw_s3.ns - tsa_pkg::NS_PER_SEC;
				sum.mag.sec = raw_s3.sec + 48'd1;
			end
		end
		sum.mag.ns = ns_fix[tsa_pkg::NS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) raw_s3 <= raw;
		if (en_s4) sum_s4 <= sum;
	end

endmodule

`default_nettype wire

// ===== rtl/core/tsa_halve.sv =====
// ----------------------------------------------------------------------------
// tsa_halve
// Stage 5: halve for average, force the unused code to zero, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_halve (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_s4,
	input  wire tsa_pkg::sum_t sum_s4,
	input  wire logic          stall,
	output logic               adv_out,
	output logic               valid_s5,
	output tsa_pkg::stamp_t    res_s5
);

	tsa_pkg::stamp_t         res;
	logic                    en_s5;
	logic [tsa_pkg::NS_W:0]  ns_odd;

	assign en_s5   = !valid_s5 || !stall;
	assign adv_out = en_s5;

	// An odd second moves into the nanoseconds before halving.
	assign ns_odd = {1'b0, sum_s4.mag.ns} +
		(sum_s4.mag.sec[0] ? tsa_pkg::NS_PER_SEC : '0);

	always_comb begin
		case (sum_s4.op)
			tsa_pkg::OP_AVG: begin
				res.pos     = sum_s4.pos;
				res.mag.sec = sum_s4.mag.sec >> 1;
				res.mag.ns  = ns_odd[tsa_pkg::NS_W:1];
			end
			tsa_pkg::OP_NONE: begin
				res.pos = 1'b1;
				res.mag = '0;
			end
			default: begin
				res.pos = sum_s4.pos;
				res.mag = sum_s4.mag;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en_s5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) res_s5 <= res;
	end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed timestamp add, subtract and average unit.
// Feeds directed corner items and random operand pairs through the
// valid/stall request channel with bursty gaps, stalls the result channel on
// its own varying pattern, and checks every result in order against an
// in-bench model of the sign and magnitude arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef tsa_pkg::op_t    op_t;
	typedef tsa_pkg::stamp_t stamp_t;
	typedef tsa_pkg::opnd_t  opnd_t;

	localparam int                SEC_W      = tsa_pkg::SEC_W;
	localparam int                NS_W       = tsa_pkg::NS_W;
	localparam logic [NS_W:0]     NS_PER_SEC = tsa_pkg::NS_PER_SEC;
	localparam logic [NS_W-1:0]   NS_MAX     = tsa_pkg::NS_MAX;

	localparam op_t OP_ADD  = tsa_pkg::OP_ADD;
	localparam op_t OP_SUB  = tsa_pkg::OP_SUB;
	localparam op_t OP_AVG  = tsa_pkg::OP_AVG;
	localparam op_t OP_NONE = tsa_pkg::OP_NONE;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 12;

	localparam logic [SEC_W-1:0] SEC_ALL = '1;
	localparam logic [NS_W-1:0]  NS_ALL  = '1;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	op_t              operation;
	logic             a_positive;
	logic [SEC_W-1:0] a_seconds;
	logic [NS_W-1:0]  a_nanos;
	logic             b_positive;
	logic [SEC_W-1:0] b_seconds;
	logic [NS_W-1:0]  b_nanos;
	logic             res_valid;
	logic             res_stall;
	logic             res_positive;
	logic [SEC_W-1:0] res_seconds;
	logic [NS_W-1:0]  res_nanos;

	// Expected results, oldest first, one per accepted item.
	stamp_t pending_results[$];
	int     error_count;
	int     idle_cycles;
	int     burst_left;

	signed_timestamp_add_sub_avg_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.a_positive   (a_positive),
		.a_seconds    (a_seconds),
		.a_nanos      (a_nanos),
		.b_positive   (b_positive),
		.b_seconds    (b_seconds),
		.b_nanos      (b_nanos),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_positive (res_positive),
		.res_seconds  (res_seconds),
		.res_nanos    (res_nanos)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Arithmetic model
	// ------------------------------------------------------------------------

	// Saturate nanoseconds above one second's worth to the top legal value.
	function automatic stamp_t clamp_nanos(stamp_t s);
		if (s.mag.ns > NS_MAX) begin
			s.mag.ns = NS_MAX;
		end
		return s;
	endfunction

	// Larger magnitude minus smaller, with the sign of the larger. Ties go to x,
	// so equal magnitudes of opposite sign give a zero carrying x's sign.
	function automatic stamp_t magnitude_diff(stamp_t x, stamp_t y);
		stamp_t      hi;
		stamp_t      lo;
		stamp_t      r;
		logic [31:0] ns_w;
		if (x.mag.sec > y.mag.sec || (x.mag.sec == y.mag.sec && x.mag.ns >= y.mag.ns)) begin
			hi = x;
			lo = y;
		end else begin
			hi = y;
			lo = x;
		end
		r.pos = hi.pos;
		if (hi.mag.ns >= lo.mag.ns) begin
			r.mag.ns  = hi.mag.ns - lo.mag.ns;
			r.mag.sec = hi.mag.sec - lo.mag.sec;
		end else begin
			// Borrow one second into the nanoseconds.
			ns_w      = {2'b00, hi.mag.ns};
			ns_w      = ns_w + NS_PER_SEC - lo.mag.ns;
			r.mag.ns  = ns_w[NS_W-1:0];
			r.mag.sec = hi.mag.sec - lo.mag.sec - 48'd1;
		end
		return r;
	endfunction

	function automatic stamp_t signed_sum(stamp_t x, stamp_t y);
		stamp_t      r;
		logic [31:0] ns_w;
		if (x.pos != y.pos) begin
			return magnitude_diff(x, y);
		end
		r.pos     = x.pos;
		ns_w      = {2'b00, x.mag.ns};
		ns_w      = ns_w + y.mag.ns;
		r.mag.sec = x.mag.sec + y.mag.sec;
		if (ns_w > NS_MAX) begin
			ns_w      = ns_w - NS_PER_SEC;
			r.mag.sec = r.mag.sec + 48'd1;
		end
		r.mag.ns = ns_w[NS_W-1:0];
		return r;
	endfunction

	function automatic stamp_t timestamp_result(opnd_t req);
		stamp_t      a;
		stamp_t      b;
		stamp_t      r;
		logic [31:0] ns_w;
		a = clamp_nanos(req.a);
		b = clamp_nanos(req.b);
		case (req.op)
			OP_ADD: begin
				r = signed_sum(a, b);
			end
			OP_SUB: begin
				// Signs are ignored: a counts as non-negative, b as negated.
				a.pos = 1'b1;
				b.pos = 1'b0;
				r     = magnitude_diff(a, b);
			end
			OP_AVG: begin
				r    = signed_sum(a, b);
				ns_w = {2'b00, r.mag.ns};
				if (r.mag.sec[0]) begin
					r.mag.sec = r.mag.sec - 48'd1;
					ns_w      = ns_w + NS_PER_SEC;
				end
				r.mag.sec = r.mag.sec >> 1;
				ns_w      = ns_w >> 1;
				r.mag.ns  = ns_w[NS_W-1:0];
			end
			default: begin
				r     = '0;
				r.pos = 1'b1;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic opnd_t operands(op_t op, logic ap, logic [SEC_W-1:0] as,
			logic [NS_W-1:0] an, logic bp, logic [SEC_W-1:0] bs, logic [NS_W-1:0] bn);
		opnd_t req;
		req.op        = op;
		req.a.pos     = ap;
		req.a.mag.sec = as;
		req.a.mag.ns  = an;
		req.b.pos     = bp;
		req.b.mag.sec = bs;
		req.b.mag.ns  = bn;
		return req;
	endfunction

	function automatic logic [SEC_W-1:0] random_seconds();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SEC_ALL;
			2: return SEC_W'($urandom_range(0, 15));
			3: return SEC_ALL - SEC_W'($urandom_range(0, 15));
			4: return SEC_W'($urandom());
			default: return w[SEC_W-1:0];
		endcase
	endfunction

	function automatic logic [NS_W-1:0] random_nanos();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return NS_MAX;
			2: return NS_W'($urandom_range(NS_MAX + 1, NS_ALL));
			3: return NS_W'($urandom_range(0, 3));
			4: return NS_MAX - NS_W'($urandom_range(0, 3));
			default: return NS_W'($urandom_range(0, NS_MAX));
		endcase
	endfunction

	// Random operand pair; b is often tied to a so that the magnitude compare,
	// the borrow and the tie paths are hit well beyond chance.
	function automatic opnd_t random_operands(op_t op);
		opnd_t req;
		req.op        = op;
		req.a.pos     = 1'($urandom_range(0, 1));
		req.b.pos     = 1'($urandom_range(0, 1));
		req.a.mag.sec = random_seconds();
		req.a.mag.ns  = random_nanos();
		req.b.mag.sec = random_seconds();
		req.b.mag.ns  = random_nanos();
		case ($urandom_range(0, 7))
			0: req.b.mag.sec = req.a.mag.sec;
			1: req.b.mag     = req.a.mag;
			2: req.b.mag.sec = req.a.mag.sec + 48'd1;
			3: req.b.mag.sec = req.a.mag.sec - 48'd1;
			4: begin
				// Same seconds, nanoseconds a hair apart in either direction.
				req.b.mag.sec = req.a.mag.sec;
				req.b.mag.ns  = req.a.mag.ns ^ NS_W'($urandom_range(1, 3));
			end
			default: ;
		endcase
		return req;
	endfunction

	// Present one item at the falling edge, hold it until accepted, then either
	// keep the burst going or drop valid for a random gap.
	task automatic send_item(opnd_t req);
		int gap;
		@(negedge clk);
		operation  <= req.op;
		a_positive <= req.a.pos;
		a_seconds  <= req.a.mag.sec;
		a_nanos    <= req.a.mag.ns;
		b_positive <= req.b.pos;
		b_seconds  <= req.b.mag.sec;
		b_nanos    <= req.b.mag.ns;
		req_valid  <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
		pending_results.push_back(timestamp_result(req));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_directed_corners();
		// Add: zeros, full-scale wrap with carry, negative pair with carry.
		send_item(operands(OP_ADD, 1, '0, '0, 1, '0, '0));
		send_item(operands(OP_ADD, 1, SEC_ALL, NS_MAX, 1, SEC_ALL, NS_MAX));
		send_item(operands(OP_ADD, 0, 48'd5, 30'd600000000, 0, 48'd7, 30'd400000000));
		// Add with unequal signs: a larger, then b larger with a borrow.
		send_item(operands(OP_ADD, 1, 48'd10, 30'd500, 0, 48'd3, 30'd200));
		send_item(operands(OP_ADD, 1, 48'd3, 30'd900000000, 0, 48'd9, 30'd100));
		// Equal magnitudes of opposite sign: zero with a's sign.
		send_item(operands(OP_ADD, 0, 48'd42, 30'd123456789, 1, 48'd42, 30'd123456789));
		send_item(operands(OP_ADD, 1, SEC_ALL, NS_MAX, 0, SEC_ALL, NS_MAX));
		// Subtract: equal stamps, a below b, a above b with borrow, signs ignored.
		send_item(operands(OP_SUB, 0, 48'd77, 30'd5, 1, 48'd77, 30'd5));
		send_item(operands(OP_SUB, 1, 48'd1, 30'd0, 1, 48'd2, 30'd1));
		send_item(operands(OP_SUB, 1, 48'd9, 30'd1, 0, 48'd4, NS_MAX));
		send_item(operands(OP_SUB, 0, SEC_ALL, NS_MAX, 1, '0, '0));
		send_item(operands(OP_SUB, 1, '0, '0, 0, SEC_ALL, NS_MAX));
		// Average: odd sum, even sum, wrap before halving, mixed signs.
		send_item(operands(OP_AVG, 1, 48'd2, 30'd1, 1, 48'd1, 30'd0));
		send_item(operands(OP_AVG, 1, 48'd4, 30'd3, 1, 48'd2, 30'd0));
		send_item(operands(OP_AVG, 1, SEC_ALL, NS_MAX, 1, SEC_ALL, NS_MAX));
		send_item(operands(OP_AVG, 0, 48'd1, 30'd0, 1, 48'd8, NS_MAX));
		send_item(operands(OP_AVG, 0, SEC_ALL, 30'd1, 0, 48'd1, NS_MAX));
		// Unused operation code, first with every field set.
		send_item(operands(OP_NONE, 1, SEC_ALL, NS_ALL, 1, SEC_ALL, NS_ALL));
		send_item(operands(OP_NONE, 0, 48'h5A5A_A5A5_1234, 30'd17, 0, '0, '0));
		// Nanoseconds out of range saturate on entry.
		send_item(operands(OP_ADD, 1, 48'd1, NS_ALL, 1, 48'd2, 30'd1));
		send_item(operands(OP_SUB, 1, 48'd6, NS_ALL, 1, 48'd6, NS_MAX + 30'd1));
		send_item(operands(OP_AVG, 0, 48'd3, NS_MAX + 30'd1, 0, '0, NS_ALL));
		send_item(operands(OP_ADD, 0, 48'd0, NS_ALL, 1, 48'd0, NS_MAX));
	endtask

	task automatic test_signed_add();
		repeat (340) send_item(random_operands(OP_ADD));
	endtask

	task automatic test_timestamp_subtract();
		repeat (300) send_item(random_operands(OP_SUB));
	endtask

	task automatic test_signed_average();
		repeat (340) send_item(random_operands(OP_AVG));
	endtask

	task automatic test_mixed_operations();
		repeat (300) send_item(random_operands(op_t'($urandom_range(0, 3))));
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Stall pattern: switch every so often between no stall, light random,
	// heavy random and long square-wave holds.
	initial begin : res_stall_pattern
		int   mode;
		int   span;
		int   run;
		logic level;
		res_stall = 1'b0;
		run       = 0;
		level     = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(32, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					2: res_stall <= ($urandom_range(0, 3) != 0);
					default: begin
						if (run <= 0) begin
							run   = $urandom_range(1, 16);
							level = ~level;
						end
						run--;
						res_stall <= level;
					end
				endcase
			end
		end
	end

	// Compare each accepted result against the oldest expectation.
	always @(posedge clk) begin : result_check
		stamp_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: res_positive %0d res_seconds %0d res_nanos %0d",
					res_positive, res_seconds, res_nanos);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_positive !== want.pos) begin
					$error("res_positive: expected %0d, actual %0d", want.pos, res_positive);
					error_count++;
				end
				if (res_seconds !== want.mag.sec) begin
					$error("res_seconds: expected %0d, actual %0d", want.mag.sec, res_seconds);
					error_count++;
				end
				if (res_nanos !== want.mag.ns) begin
					$error("res_nanos: expected %0d, actual %0d", want.mag.ns, res_nanos);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		error_count = 0;
		idle_cycles = 0;
		burst_left  = 1;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		operation   = OP_ADD;
		a_positive  = 1'b0;
		a_seconds   = '0;
		a_nanos     = '0;
		b_positive  = 1'b0;
		b_seconds   = '0;
		b_nanos     = '0;

		// Hold reset, then release it away from the rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_signed_add();
		test_timestamp_subtract();
		test_signed_average();
		test_mixed_operations();

		// Drop valid so the last item is not sent twice, then drain.
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== signed_timestamp_add_sub_avg_top.f =====
+incdir+rtl/core
rtl/core/tsa_pkg.sv
rtl/core/tsa_order.sv
rtl/core/tsa_addsub.sv
rtl/core/tsa_halve.sv
rtl/core/signed_timestamp_add_sub_avg_top.sv
dv/tb_top.sv
